@@ rtl/core/rle8_indexed_bitmap_decoder_assert.svh @@
// Assertion macros used by the checker file of the bitmap decoder.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef RLE8_INDEXED_BITMAP_DECODER_ASSERT_SVH
`define RLE8_INDEXED_BITMAP_DECODER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define RLE8BMP_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define RLE8BMP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/rle8bmp_pkg.sv @@
package rle8bmp_pkg;

  // Image dimension limit and colour table size.
  localparam int MAX_DIMENSION   = 4096;
  localparam int PALETTE_ENTRIES = 256;

  // Fixed field widths of the ports.
  localparam int CFG_DIM_W  = 13;
  localparam int CFG_DATA_W = 13;
  localparam int CFG_IDX_W  = 2;
  localparam int COORD_W    = 12;
  localparam int BYTE_W     = 8;
  localparam int LEN_W      = 8;
  localparam int KIND_W     = 2;
  localparam int CMD_W      = 2;
  localparam int RGB_W      = 24;

  // Position counters must reach MAX_DIMENSION itself.
  localparam int DIM_W   = $clog2(MAX_DIMENSION + 1);
  localparam int SUM_W   = ((DIM_W > LEN_W) ? DIM_W : LEN_W) + 1;
  localparam int CLAMP_W = (DIM_W > CFG_DIM_W) ? DIM_W : CFG_DIM_W;
  localparam int PAL_AW  = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;

  // Decoupling queue between the front and back parts.
  localparam int QUEUE_DEPTH = 4;
  localparam int Q_AW        = $clog2(QUEUE_DEPTH);

  // Input commands.
  localparam logic [CMD_W-1:0] CMD_PAL_WRITE = 2'd0;
  localparam logic [CMD_W-1:0] CMD_DATA      = 2'd1;
  localparam logic [CMD_W-1:0] CMD_NEW_IMAGE = 2'd2;

  // Record kinds.
  localparam logic [KIND_W-1:0] KIND_RUN   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_END   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_ERROR = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MODE   = 2'd2;

  // RLE8 escape codes that follow a zero count byte.
  localparam logic [BYTE_W-1:0] ESC_END_LINE  = 8'd0;
  localparam logic [BYTE_W-1:0] ESC_END_IMAGE = 8'd1;
  localparam logic [BYTE_W-1:0] ESC_DELTA     = 8'd2;

  // One operation for the back part: a colour table write or an output record.
  typedef struct packed {
    logic                is_pal;
    logic [KIND_W-1:0]   kind;
    logic [COORD_W-1:0]  x;
    logic [COORD_W-1:0]  y;
    logic [BYTE_W-1:0]   idx;
    logic [LEN_W-1:0]    len;
    logic                colour_hit;
    logic [RGB_W-1:0]    rgb;
  } q_entry_t;

  typedef struct packed {
    logic     valid;
    q_entry_t entry;
  } q_slot_t;

endpackage

@@ rtl/core/rle8bmp_fifo.sv @@
module rle8bmp_fifo (
  input  logic                clk,
  input  logic                rst_n,
  input  rle8bmp_pkg::q_slot_t push,
  input  logic                pop,
  output rle8bmp_pkg::q_slot_t head,
  output logic                full
);

  rle8bmp_pkg::q_entry_t           slots_r [rle8bmp_pkg::QUEUE_DEPTH];
  logic [rle8bmp_pkg::Q_AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [rle8bmp_pkg::Q_AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [rle8bmp_pkg::Q_AW:0]      count_r, count_nxt;
  logic                            do_push;
  logic                            do_pop;

  assign do_push = push.valid && !full;
  assign do_pop  = pop && (count_r != '0);
  assign full    = (count_r == (rle8bmp_pkg::Q_AW+1)'(rle8bmp_pkg::QUEUE_DEPTH));

  assign head.valid = (count_r != '0);
  assign head.entry = slots_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots_r[wr_ptr_r] <= push.entry;
    end
  end

endmodule

@@ rtl/core/rle8bmp_front.sv @@
module rle8bmp_front (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [rle8bmp_pkg::CMD_W-1:0]         in_command,
  input  logic [rle8bmp_pkg::BYTE_W-1:0]        in_palette_index,
  input  logic [rle8bmp_pkg::BYTE_W-1:0]        in_palette_red,
  input  logic [rle8bmp_pkg::BYTE_W-1:0]        in_palette_green,
  input  logic [rle8bmp_pkg::BYTE_W-1:0]        in_palette_blue,
  input  logic [rle8bmp_pkg::BYTE_W-1:0]        in_data_byte,
  input  logic                                  cfg_write_enable,
  input  logic [rle8bmp_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [rle8bmp_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                                  q_full,
  output rle8bmp_pkg::q_slot_t                  push
);

  typedef enum logic [6:0] {
    PH_COUNT   = 7'b0000001,
    PH_VALUE   = 7'b0000010,
    PH_ESCAPE  = 7'b0000100,
    PH_DX      = 7'b0001000,
    PH_DY      = 7'b0010000,
    PH_LITERAL = 7'b0100000,
    PH_PAD     = 7'b1000000
  } phase_t;

  localparam int DIM_W = rle8bmp_pkg::DIM_W;
  localparam int SUM_W = rle8bmp_pkg::SUM_W;

  function automatic logic [DIM_W-1:0] clamp_dim(
    input logic [rle8bmp_pkg::CFG_DIM_W-1:0] v
  );
    logic [rle8bmp_pkg::CLAMP_W-1:0] vw;
    vw = rle8bmp_pkg::CLAMP_W'(v);
    if (v == '0) begin
      return DIM_W'(1);
    end
    if (vw > rle8bmp_pkg::CLAMP_W'(rle8bmp_pkg::MAX_DIMENSION)) begin
      return DIM_W'(rle8bmp_pkg::MAX_DIMENSION);
    end
    return DIM_W'(vw);
  endfunction

  function automatic logic [DIM_W-1:0] sat_dim(input logic [SUM_W-1:0] s);
    if (s > SUM_W'(rle8bmp_pkg::MAX_DIMENSION)) begin
      return DIM_W'(rle8bmp_pkg::MAX_DIMENSION);
    end
    return DIM_W'(s);
  endfunction

  logic [rle8bmp_pkg::CFG_DIM_W-1:0] cfg_width_r;
  logic [rle8bmp_pkg::CFG_DIM_W-1:0] cfg_height_r;
  logic                              cfg_mode_r;

  phase_t                            phase_r, phase_nxt;
  logic [DIM_W-1:0]                  col_r, col_nxt;
  logic [DIM_W-1:0]                  row_r, row_nxt;
  logic [rle8bmp_pkg::LEN_W-1:0]     held_r, held_nxt;
  logic [rle8bmp_pkg::LEN_W-1:0]     lit_r, lit_nxt;
  logic [1:0]                        pad_r, pad_nxt;
  logic                              done_r, done_nxt;

  logic                              accept;
  logic [DIM_W-1:0]                  w_eff;
  logic [DIM_W-1:0]                  h_eff;
  logic [rle8bmp_pkg::LEN_W-1:0]     run_len;
  logic [SUM_W-1:0]                  run_end;
  logic                              run_fits;
  logic                              idx_in_table;
  logic                              pal_in_table;
  logic [DIM_W-1:0]                  row_inc;
  logic [DIM_W-1:0]                  row_add;
  logic [DIM_W-1:0]                  col_add;
  logic [1:0]                        raw_pad;
  logic                              emit;
  logic                              raw_wrap;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  assign w_eff    = clamp_dim(cfg_width_r);
  assign h_eff    = clamp_dim(cfg_height_r);
  assign run_len  = (cfg_mode_r && (phase_r == PH_VALUE)) ? held_r
                                                          : rle8bmp_pkg::LEN_W'(1);
  assign run_end  = SUM_W'(col_r) + SUM_W'(run_len);
  assign run_fits = (row_r < h_eff) && (run_end <= SUM_W'(w_eff));
  assign row_inc  = sat_dim(SUM_W'(row_r) + SUM_W'(1));
  assign row_add  = sat_dim(SUM_W'(row_r) + SUM_W'(in_data_byte));
  assign col_add  = sat_dim(SUM_W'(col_r) + SUM_W'(held_r));
  assign raw_pad  = 2'd0 - w_eff[1:0];

  assign idx_in_table = ({1'b0, in_data_byte} < 9'(rle8bmp_pkg::PALETTE_ENTRIES));
  assign pal_in_table = ({1'b0, in_palette_index} < 9'(rle8bmp_pkg::PALETTE_ENTRIES));

  always_comb begin
    phase_nxt = phase_r;
    col_nxt   = col_r;
    row_nxt   = row_r;
    held_nxt  = held_r;
    lit_nxt   = lit_r;
    pad_nxt   = pad_r;
    done_nxt  = done_r;
    emit      = 1'b0;
    raw_wrap  = 1'b0;

    push.valid            = 1'b0;
    push.entry.is_pal     = 1'b0;
    push.entry.kind       = rle8bmp_pkg::KIND_ERROR;
    push.entry.x          = rle8bmp_pkg::COORD_W'(col_r);
    push.entry.y          = rle8bmp_pkg::COORD_W'(row_r);
    push.entry.idx        = in_data_byte;
    push.entry.len        = run_len;
    push.entry.colour_hit = 1'b0;
    push.entry.rgb        = {in_palette_red, in_palette_green, in_palette_blue};

    if (accept) begin
      case (in_command)
        rle8bmp_pkg::CMD_PAL_WRITE: begin
          push.valid        = pal_in_table;
          push.entry.is_pal = 1'b1;
          push.entry.idx    = in_palette_index;
        end
        rle8bmp_pkg::CMD_NEW_IMAGE: begin
          phase_nxt = PH_COUNT;
          col_nxt   = '0;
          row_nxt   = '0;
          held_nxt  = '0;
          lit_nxt   = '0;
          pad_nxt   = '0;
          done_nxt  = 1'b0;
        end
        rle8bmp_pkg::CMD_DATA: begin
          if (done_r) begin
            push.valid     = 1'b1;
            push.entry.len = rle8bmp_pkg::LEN_W'(1);
          end else if (cfg_mode_r) begin
            case (phase_r)
              PH_VALUE: begin
                emit      = 1'b1;
                phase_nxt = PH_COUNT;
              end
              PH_ESCAPE: begin
                case (in_data_byte)
                  rle8bmp_pkg::ESC_END_LINE: begin
                    col_nxt   = '0;
                    row_nxt   = row_inc;
                    phase_nxt = PH_COUNT;
                  end
                  rle8bmp_pkg::ESC_END_IMAGE: begin
                    done_nxt        = 1'b1;
                    phase_nxt       = PH_COUNT;
                    push.valid      = 1'b1;
                    push.entry.kind = rle8bmp_pkg::KIND_END;
                    push.entry.len  = '0;
                  end
                  rle8bmp_pkg::ESC_DELTA: begin
                    phase_nxt = PH_DX;
                  end
                  default: begin
                    lit_nxt   = in_data_byte;
                    pad_nxt   = {1'b0, in_data_byte[0]};
                    phase_nxt = PH_LITERAL;
                  end
                endcase
              end
              PH_DX: begin
                held_nxt  = in_data_byte;
                phase_nxt = PH_DY;
              end
              PH_DY: begin
                col_nxt   = col_add;
                row_nxt   = row_add;
                phase_nxt = PH_COUNT;
              end
              PH_LITERAL: begin
                emit    = 1'b1;
                lit_nxt = lit_r - 1'b1;
                if (lit_r == rle8bmp_pkg::LEN_W'(1)) begin
                  phase_nxt = (pad_r != '0) ? PH_PAD : PH_COUNT;
                end
              end
              PH_PAD: begin
                pad_nxt   = '0;
                phase_nxt = PH_COUNT;
              end
              default: begin
                if (in_data_byte != '0) begin
                  held_nxt  = in_data_byte;
                  phase_nxt = PH_VALUE;
                end else begin
                  phase_nxt = PH_ESCAPE;
                end
              end
            endcase
          end else begin
            if (pad_r != '0) begin
              pad_nxt = pad_r - 1'b1;
              if ((pad_r == 2'd1) && (row_r >= h_eff)) begin
                done_nxt = 1'b1;
              end
            end else begin
              emit     = 1'b1;
              raw_wrap = run_fits && (run_end >= SUM_W'(w_eff));
            end
          end
        end
        default: begin
        end
      endcase
    end

    // A run that fits advances the column; one that does not is reported.
    if (emit) begin
      push.valid = 1'b1;
      if (run_fits) begin
        push.entry.kind       = rle8bmp_pkg::KIND_RUN;
        push.entry.colour_hit = idx_in_table;
        col_nxt               = DIM_W'(run_end);
      end
    end

    // Raw rows wrap at the image width and then skip their padding bytes.
    if (raw_wrap) begin
      col_nxt = '0;
      row_nxt = row_inc;
      pad_nxt = raw_pad;
      if ((raw_pad == '0) && (row_inc >= h_eff)) begin
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_width_r  <= rle8bmp_pkg::CFG_DIM_W'(640);
      cfg_height_r <= rle8bmp_pkg::CFG_DIM_W'(480);
      cfg_mode_r   <= 1'b0;
    end else if (cfg_write_enable) begin
      case (cfg_index)
        rle8bmp_pkg::REG_WIDTH:  cfg_width_r  <= rle8bmp_pkg::CFG_DIM_W'(cfg_data);
        rle8bmp_pkg::REG_HEIGHT: cfg_height_r <= rle8bmp_pkg::CFG_DIM_W'(cfg_data);
        rle8bmp_pkg::REG_MODE:   cfg_mode_r   <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_COUNT;
      col_r   <= '0;
      row_r   <= '0;
      held_r  <= '0;
      lit_r   <= '0;
      pad_r   <= '0;
      done_r  <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      col_r   <= col_nxt;
      row_r   <= row_nxt;
      held_r  <= held_nxt;
      lit_r   <= lit_nxt;
      pad_r   <= pad_nxt;
      done_r  <= done_nxt;
    end
  end

endmodule

@@ rtl/core/rle8bmp_back.sv @@
module rle8bmp_back (
  input  logic                               clk,
  input  logic                               rst_n,
  input  rle8bmp_pkg::q_slot_t               head,
  output logic                               pop,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [rle8bmp_pkg::KIND_W-1:0]     out_record_kind,
  output logic [rle8bmp_pkg::COORD_W-1:0]    out_pixel_x,
  output logic [rle8bmp_pkg::COORD_W-1:0]    out_pixel_y,
  output logic [rle8bmp_pkg::BYTE_W-1:0]     out_red,
  output logic [rle8bmp_pkg::BYTE_W-1:0]     out_green,
  output logic [rle8bmp_pkg::BYTE_W-1:0]     out_blue,
  output logic [rle8bmp_pkg::LEN_W-1:0]      out_run_length
);

  logic [rle8bmp_pkg::RGB_W-1:0]   palette_mem [rle8bmp_pkg::PALETTE_ENTRIES];
  logic [rle8bmp_pkg::RGB_W-1:0]   rd_data_r;
  logic [rle8bmp_pkg::PAL_AW-1:0]  pal_addr;

  logic                            out_valid_r;
  logic [rle8bmp_pkg::KIND_W-1:0]  kind_r;
  logic [rle8bmp_pkg::COORD_W-1:0] x_r;
  logic [rle8bmp_pkg::COORD_W-1:0] y_r;
  logic [rle8bmp_pkg::LEN_W-1:0]   len_r;
  logic                            hit_r;

  logic                            pal_write;
  logic                            rec_load;

  assign pal_addr = rle8bmp_pkg::PAL_AW'(head.entry.idx);

  // Table writes never wait on the output; records wait for a free output register.
  assign pop       = head.valid && (head.entry.is_pal || !out_valid_r || !out_stall);
  assign pal_write = pop && head.entry.is_pal;
  assign rec_load  = pop && !head.entry.is_pal;

  always_ff @(posedge clk) begin
    if (pal_write) begin
      palette_mem[pal_addr] <= head.entry.rgb;
    end
    if (rec_load) begin
      rd_data_r <= palette_mem[pal_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (rec_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rec_load) begin
      kind_r <= head.entry.kind;
      x_r    <= head.entry.x;
      y_r    <= head.entry.y;
      len_r  <= head.entry.len;
      hit_r  <= head.entry.colour_hit;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_record_kind = kind_r;
  assign out_pixel_x     = x_r;
  assign out_pixel_y     = y_r;
  assign out_run_length  = len_r;
  assign out_red         = hit_r ? rd_data_r[23:16] : '0;
  assign out_green       = hit_r ? rd_data_r[15:8]  : '0;
  assign out_blue        = hit_r ? rd_data_r[7:0]   : '0;

endmodule

@@ rtl/core/rle8_indexed_bitmap_decoder.sv @@
// Decoder for the pixel data of 8-bit indexed bitmaps, raw or RLE8 coded. Colour
// table writes (command 0), data bytes (command 1) and image restarts (command 2)
// arrive on the in_ channel; every completed pixel run leaves on the out_ channel
// as one record with its position, its colour from the table and its length, and
// runs that fall outside the configured image leave as position error records.
// The block takes one item per clock cycle while in_stall is low. On its way out
// a record is held first in a queue slot, written at the transfer of the byte that
// completes it, and then in the output register, loaded together with the colour
// table read once that slot is at the queue head and the output register is free.
// in_stall rises only when the four-entry queue between the decoder and the table
// is full, which happens only while the consumer holds out_stall. Write the
// registers only while the block is idle, and write every colour table entry
// before a run refers to it.

module rle8_indexed_bitmap_decoder (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [rle8bmp_pkg::CMD_W-1:0]         in_command,
  input  logic [rle8bmp_pkg::BYTE_W-1:0]        in_palette_index,
  input  logic [rle8bmp_pkg::BYTE_W-1:0]        in_palette_red,
  input  logic [rle8bmp_pkg::BYTE_W-1:0]        in_palette_green,
  input  logic [rle8bmp_pkg::BYTE_W-1:0]        in_palette_blue,
  input  logic [rle8bmp_pkg::BYTE_W-1:0]        in_data_byte,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [rle8bmp_pkg::KIND_W-1:0]        out_record_kind,
  output logic [rle8bmp_pkg::COORD_W-1:0]       out_pixel_x,
  output logic [rle8bmp_pkg::COORD_W-1:0]       out_pixel_y,
  output logic [rle8bmp_pkg::BYTE_W-1:0]        out_red,
  output logic [rle8bmp_pkg::BYTE_W-1:0]        out_green,
  output logic [rle8bmp_pkg::BYTE_W-1:0]        out_blue,
  output logic [rle8bmp_pkg::LEN_W-1:0]         out_run_length,
  input  logic                                  cfg_write_enable,
  input  logic [rle8bmp_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [rle8bmp_pkg::CFG_DATA_W-1:0]    cfg_data
);

  // The front part runs the decode state machine on every transfer and turns
  // each transfer into at most one operation: a colour table write or a record.
  rle8bmp_pkg::q_slot_t push;
  rle8bmp_pkg::q_slot_t head;
  logic                 q_full;
  logic                 pop;

  rle8bmp_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_command       (in_command),
    .in_palette_index (in_palette_index),
    .in_palette_red   (in_palette_red),
    .in_palette_green (in_palette_green),
    .in_palette_blue  (in_palette_blue),
    .in_data_byte     (in_data_byte),
    .cfg_write_enable (cfg_write_enable),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .q_full           (q_full),
    .push             (push)
  );

  // Table writes travel through the same queue as records, so a run always sees
  // every colour written before it in the input stream.
  rle8bmp_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .pop   (pop),
    .head  (head),
    .full  (q_full)
  );

  // The back part owns the colour table and the output register. It reads the
  // table as a record enters the output register and holds it there under stall.
  rle8bmp_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .head            (head),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_record_kind (out_record_kind),
    .out_pixel_x     (out_pixel_x),
    .out_pixel_y     (out_pixel_y),
    .out_red         (out_red),
    .out_green       (out_green),
    .out_blue        (out_blue),
    .out_run_length  (out_run_length)
  );

endmodule

@@ rtl/core/rle8bmp_checker.sv @@
`include "rle8_indexed_bitmap_decoder_assert.svh"

module rle8bmp_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               out_valid,
  input logic                               out_stall,
  input logic [rle8bmp_pkg::KIND_W-1:0]     out_record_kind,
  input logic [rle8bmp_pkg::COORD_W-1:0]    out_pixel_x,
  input logic [rle8bmp_pkg::COORD_W-1:0]    out_pixel_y,
  input logic [rle8bmp_pkg::BYTE_W-1:0]     out_red,
  input logic [rle8bmp_pkg::BYTE_W-1:0]     out_green,
  input logic [rle8bmp_pkg::BYTE_W-1:0]     out_blue,
  input logic [rle8bmp_pkg::LEN_W-1:0]      out_run_length
);

  `RLE8BMP_ASSERT_NEXT(a_out_valid_held, out_valid && out_stall, out_valid, "record dropped under stall")

  `RLE8BMP_ASSERT_NEXT(a_out_pos_held, out_valid && out_stall, $stable(out_pixel_x) && $stable(out_pixel_y) && $stable(out_record_kind), "record changed under stall")

  `RLE8BMP_ASSERT_SAME(a_no_colour, out_valid && (out_record_kind != rle8bmp_pkg::KIND_RUN), (out_red == '0) && (out_green == '0) && (out_blue == '0), "colour on a non-run record")

  `RLE8BMP_ASSERT_SAME(a_run_len, out_valid && (out_record_kind == rle8bmp_pkg::KIND_RUN), out_run_length != '0, "pixel run of length zero")

  `RLE8BMP_ASSERT_SAME(a_end_len, out_valid && (out_record_kind == rle8bmp_pkg::KIND_END), out_run_length == '0, "end record with a length")

endmodule

bind rle8_indexed_bitmap_decoder rle8bmp_checker u_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_record_kind (out_record_kind),
  .out_pixel_x     (out_pixel_x),
  .out_pixel_y     (out_pixel_y),
  .out_red         (out_red),
  .out_green       (out_green),
  .out_blue        (out_blue),
  .out_run_length  (out_run_length)
);

@@ tb/tb_top.sv @@
module tb_top;
  import rle8bmp_pkg::*;

  // One item on the input channel, laid out the way the ports are.
  typedef struct packed {
    logic [CMD_W-1:0]  command;
    logic [BYTE_W-1:0] palette_index;
    logic [BYTE_W-1:0] palette_red;
    logic [BYTE_W-1:0] palette_green;
    logic [BYTE_W-1:0] palette_blue;
    logic [BYTE_W-1:0] data_byte;
  } stream_item_t;

  // One record on the output channel.
  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [BYTE_W-1:0]  red;
    logic [BYTE_W-1:0]  green;
    logic [BYTE_W-1:0]  blue;
    logic [LEN_W-1:0]   run_length;
  } pixel_record_t;

  // Where the RLE8 byte parser stands between two data bytes.
  typedef enum logic [2:0] {
    RLE_COUNT, RLE_VALUE, RLE_ESCAPE, RLE_DX, RLE_DY, RLE_LITERAL, RLE_PAD
  } rle_phase_t;

  typedef enum logic [1:0] {
    STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC
  } stall_pattern_t;

  // The command code the block has no use for; it must be dropped silently.
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  // A zero count byte opens an escape: one of the package escape codes, or the
  // length of an absolute run.
  localparam logic [BYTE_W-1:0] ESC_LEAD = 8'd0;

  localparam int TOTAL_ITEMS    = 400;  // items in the whole stream, directed ones included
  localparam int SETTLE_CYCLES  = 8;    // drain time for items that give no record
  localparam int WATCHDOG_LIMIT = 500;  // quiet cycles tolerated before giving up
  localparam int MAX_STALL_RUN  = 12;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [CMD_W-1:0]      in_command = '0;
  logic [BYTE_W-1:0]     in_palette_index = '0;
  logic [BYTE_W-1:0]     in_palette_red = '0;
  logic [BYTE_W-1:0]     in_palette_green = '0;
  logic [BYTE_W-1:0]     in_palette_blue = '0;
  logic [BYTE_W-1:0]     in_data_byte = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [KIND_W-1:0]     out_record_kind;
  logic [COORD_W-1:0]    out_pixel_x;
  logic [COORD_W-1:0]    out_pixel_y;
  logic [BYTE_W-1:0]     out_red;
  logic [BYTE_W-1:0]     out_green;
  logic [BYTE_W-1:0]     out_blue;
  logic [LEN_W-1:0]      out_run_length;
  logic                  cfg_write_enable = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  rle8_indexed_bitmap_decoder dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_command       (in_command),
    .in_palette_index (in_palette_index),
    .in_palette_red   (in_palette_red),
    .in_palette_green (in_palette_green),
    .in_palette_blue  (in_palette_blue),
    .in_data_byte     (in_data_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_record_kind  (out_record_kind),
    .out_pixel_x      (out_pixel_x),
    .out_pixel_y      (out_pixel_y),
    .out_red          (out_red),
    .out_green        (out_green),
    .out_blue         (out_blue),
    .out_run_length   (out_run_length),
    .cfg_write_enable (cfg_write_enable),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Decoder shadow. It mirrors the registers, the colour table and the parser
  // state, and turns every accepted input transfer into the record it should
  // produce, if any. The register copies start at their reset values.
  // ---------------------------------------------------------------------------
  logic [CFG_DIM_W-1:0] shadow_width  = 13'd640;
  logic [CFG_DIM_W-1:0] shadow_height = 13'd480;
  logic                 shadow_rle    = 1'b0;
  logic [RGB_W-1:0]     colour_table [PALETTE_ENTRIES];
  rle_phase_t           parse_phase   = RLE_COUNT;
  int unsigned          cur_col       = 0;
  int unsigned          cur_row       = 0;
  int unsigned          held_count    = 0;
  int unsigned          literal_left  = 0;
  int unsigned          pad_left      = 0;
  bit                   image_done    = 1'b0;

  pixel_record_t expected_records [$];
  stream_item_t  stream_q [$];

  int unsigned items_pushed   = 0;
  int unsigned ignored_items  = 0;
  int unsigned items_accepted = 0;
  int unsigned records_seen   = 0;
  int unsigned error_count    = 0;

  initial begin
    for (int i = 0; i < PALETTE_ENTRIES; i++) colour_table[i] = '0;
  end

  // Out-of-range dimension registers: zero behaves as one, anything past the
  // maximum behaves as the maximum.
  function automatic int unsigned clamp_dim(logic [CFG_DIM_W-1:0] v);
    if (v == 0) return 1;
    if (v > MAX_DIMENSION) return MAX_DIMENSION;
    return v;
  endfunction

  // Delta and end of line move the position, but never past the maximum.
  function automatic int unsigned sat_add(int unsigned a, int unsigned b);
    return (a + b > MAX_DIMENSION) ? MAX_DIMENSION : a + b;
  endfunction

  function automatic logic [BYTE_W-1:0] any_byte();
    return BYTE_W'($urandom);
  endfunction

  // Coordinates are held wide enough to reach the maximum, but the ports only
  // carry their low twelve bits.
  function automatic void expect_record(logic [KIND_W-1:0] kind, int unsigned x,
                                        int unsigned y, logic [RGB_W-1:0] rgb,
                                        int unsigned len);
    pixel_record_t rec;
    rec.kind = kind;
    rec.x = x[COORD_W-1:0];
    rec.y = y[COORD_W-1:0];
    {rec.red, rec.green, rec.blue} = rgb;
    rec.run_length = len[LEN_W-1:0];
    expected_records.push_back(rec);
  endfunction

  // A run that does not fit the image becomes a position error and leaves the
  // position where it was. Returns whether the run was placed.
  function automatic bit place_run(logic [BYTE_W-1:0] idx, int unsigned len);
    if (cur_row >= clamp_dim(shadow_height) || cur_col + len > clamp_dim(shadow_width)) begin
      expect_record(KIND_ERROR, cur_col, cur_row, '0, len);
      return 1'b0;
    end
    expect_record(KIND_RUN, cur_col, cur_row, colour_table[idx], len);
    cur_col = cur_col + len;
    return 1'b1;
  endfunction

  function automatic void clear_image();
    parse_phase  = RLE_COUNT;
    cur_col      = 0;
    cur_row      = 0;
    held_count   = 0;
    literal_left = 0;
    pad_left     = 0;
    image_done   = 1'b0;
  endfunction

  // Raw mode: every byte is one pixel, and each row is padded to a multiple of four bytes.
  // The padding counter is shared with the RLE8 parser, so a mode change in
  // the middle of an image carries any pending pad byte across.
  function automatic void decode_raw(logic [BYTE_W-1:0] code);
    int unsigned w;
    int unsigned h;
    w = clamp_dim(shadow_width);
    h = clamp_dim(shadow_height);
    if (pad_left != 0) begin
      pad_left = (pad_left - 1) & 3;
      if (pad_left == 0 && cur_row >= h) image_done = 1'b1;
    end else if (place_run(code, 1) && cur_col >= w) begin
      cur_col  = 0;
      cur_row  = sat_add(cur_row, 1);
      pad_left = (4 - (w % 4)) % 4;
      if (pad_left == 0 && cur_row >= h) image_done = 1'b1;
    end
  endfunction

  function automatic void decode_rle(logic [BYTE_W-1:0] code);
    case (parse_phase)
      RLE_VALUE: begin
        void'(place_run(code, held_count));
        parse_phase = RLE_COUNT;
      end
      RLE_ESCAPE: begin
        if (code == ESC_END_LINE) begin
          cur_col     = 0;
          cur_row     = sat_add(cur_row, 1);
          parse_phase = RLE_COUNT;
        end else if (code == ESC_END_IMAGE) begin
          image_done  = 1'b1;
          parse_phase = RLE_COUNT;
          expect_record(KIND_END, cur_col, cur_row, '0, 0);
        end else if (code == ESC_DELTA) begin
          parse_phase = RLE_DX;
        end else begin
          // Absolute run; an odd length is followed by one pad byte.
          literal_left = code;
          pad_left     = code & 1;
          parse_phase  = RLE_LITERAL;
        end
      end
      RLE_DX: begin
        held_count  = code;
        parse_phase = RLE_DY;
      end
      RLE_DY: begin
        cur_col     = sat_add(cur_col, held_count);
        cur_row     = sat_add(cur_row, code);
        parse_phase = RLE_COUNT;
      end
      RLE_LITERAL: begin
        void'(place_run(code, 1));
        literal_left = (literal_left - 1) & 8'hFF;
        if (literal_left == 0) parse_phase = (pad_left != 0) ? RLE_PAD : RLE_COUNT;
      end
      RLE_PAD: begin
        pad_left    = 0;
        parse_phase = RLE_COUNT;
      end
      default: begin
        if (code != ESC_LEAD) begin
          held_count  = code;
          parse_phase = RLE_VALUE;
        end else begin
          parse_phase = RLE_ESCAPE;
        end
      end
    endcase
  endfunction

  function automatic void decode_item(stream_item_t it);
    case (it.command)
      CMD_PAL_WRITE:
        colour_table[it.palette_index] = {it.palette_red, it.palette_green, it.palette_blue};
      CMD_NEW_IMAGE: clear_image();
      CMD_DATA: begin
        // Once the image is finished, every byte is refused at the position held.
        if (image_done) expect_record(KIND_ERROR, cur_col, cur_row, '0, 1);
        else if (shadow_rle) decode_rle(it.data_byte);
        else decode_raw(it.data_byte);
      end
      default: ;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Input driver. Items leave the pending queue in bursts of random length
  // with random gaps between them; some bursts are long enough to keep the
  // channel busy for a stretch. A payload stays put until its transfer.
  // ---------------------------------------------------------------------------
  stream_item_t held_item = '0;
  int unsigned  burst_left = 0;
  int unsigned  gap_left = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        decode_item(held_item);
        items_accepted++;
      end
      if (!in_valid || !in_stall) begin
        if (gap_left != 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (stream_q.size() != 0) begin
          held_item = stream_q.pop_front();
          in_valid         <= 1'b1;
          in_command       <= held_item.command;
          in_palette_index <= held_item.palette_index;
          in_palette_red   <= held_item.palette_red;
          in_palette_green <= held_item.palette_green;
          in_palette_blue  <= held_item.palette_blue;
          in_data_byte     <= held_item.data_byte;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 90)
                                                     : $urandom_range(1, 10);
            gap_left = $urandom_range(1, 6);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Output monitor. Every record transfer is checked field by field against
  // the oldest prediction. The stall line follows a pattern that is picked anew
  // at random intervals: none, light, heavy or periodic. A cap on consecutive
  // stalled cycles keeps the heavy pattern from starving the channel.
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(input string what, input int unsigned got_v,
                                 input int unsigned want_v);
    error_count++;
    $display("record %0d: %s got %0d, expected %0d", records_seen, what, got_v, want_v);
  endtask

  stall_pattern_t stall_mode = STALL_NONE;
  int unsigned    stall_mode_left = 0;
  int unsigned    stall_run = 0;
  int unsigned    stall_tick = 0;
  logic           stall_next;
  pixel_record_t  got_record;
  pixel_record_t  want_record;

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        records_seen++;
        got_record.kind = out_record_kind;
        got_record.x = out_pixel_x;
        got_record.y = out_pixel_y;
        got_record.red = out_red;
        got_record.green = out_green;
        got_record.blue = out_blue;
        got_record.run_length = out_run_length;
        if (expected_records.size() == 0) begin
          report_mismatch("unexpected record of kind", got_record.kind, 0);
        end else begin
          want_record = expected_records.pop_front();
          if (got_record.kind != want_record.kind)
            report_mismatch("record_kind", got_record.kind, want_record.kind);
          if (got_record.x != want_record.x)
            report_mismatch("pixel_x", got_record.x, want_record.x);
          if (got_record.y != want_record.y)
            report_mismatch("pixel_y", got_record.y, want_record.y);
          if (got_record.red != want_record.red)
            report_mismatch("red", got_record.red, want_record.red);
          if (got_record.green != want_record.green)
            report_mismatch("green", got_record.green, want_record.green);
          if (got_record.blue != want_record.blue)
            report_mismatch("blue", got_record.blue, want_record.blue);
          if (got_record.run_length != want_record.run_length)
            report_mismatch("run_length", got_record.run_length, want_record.run_length);
        end
      end

      if (stall_mode_left == 0) begin
        stall_mode = stall_pattern_t'($urandom_range(0, 3));
        stall_mode_left = $urandom_range(16, 80);
      end else begin
        stall_mode_left--;
      end
      stall_tick++;
      case (stall_mode)
        STALL_LIGHT:    stall_next = ($urandom_range(0, 3) == 0);
        STALL_HEAVY:    stall_next = ($urandom_range(0, 3) != 0);
        STALL_PERIODIC: stall_next = ((stall_tick % 5) < 2);
        default:        stall_next = 1'b0;
      endcase
      if (stall_run >= MAX_STALL_RUN) stall_next = 1'b0;
      stall_run = stall_next ? stall_run + 1 : 0;
      out_stall <= stall_next;
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: a run of cycles with no transfer on either channel means the
  // block has hung or lost a record.
  // ---------------------------------------------------------------------------
  int unsigned quiet_cycles = 0;

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus and sequencing.
  // ---------------------------------------------------------------------------
  function automatic void push_item(logic [CMD_W-1:0] cmd, logic [BYTE_W-1:0] idx,
                                    logic [RGB_W-1:0] rgb, logic [BYTE_W-1:0] code);
    stream_item_t it;
    it.command = cmd;
    it.palette_index = idx;
    {it.palette_red, it.palette_green, it.palette_blue} = rgb;
    it.data_byte = code;
    stream_q.push_back(it);
    items_pushed++;
    if (cmd == CMD_UNUSED) ignored_items++;
  endfunction

  // Fields that a data byte does not use still carry random values.
  function automatic void push_byte(logic [BYTE_W-1:0] code);
    push_item(CMD_DATA, any_byte(), RGB_W'($urandom), code);
  endfunction

  function automatic logic [CFG_DIM_W-1:0] pick_dimension(int unsigned usual_max);
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2: return CFG_DIM_W'(MAX_DIMENSION);
      3: return CFG_DIM_W'($urandom_range(0, (1 << CFG_DIM_W) - 1));
      default: return CFG_DIM_W'($urandom_range(1, usual_max));
    endcase
  endfunction

  // Waits until every pending item has been transferred and every predicted
  // record has arrived, then lets the pipeline drain items that give no record.
  task automatic wait_idle();
    while (items_accepted != items_pushed || expected_records.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Register writes, one per cycle, only while the block is idle. The caller
  // stands at a rising edge. The mask selects which registers are written.
  task automatic configure(logic [CFG_DIM_W-1:0] width_val, logic [CFG_DIM_W-1:0] height_val,
                           logic mode_val, logic [2:0] write_mask);
    logic [CFG_DATA_W-1:0] reg_value [3];
    reg_value[REG_WIDTH]  = width_val;
    reg_value[REG_HEIGHT] = height_val;
    reg_value[REG_MODE]   = CFG_DATA_W'(mode_val);
    for (int r = 0; r < 3; r++) begin
      if (write_mask[r]) begin
        cfg_write_enable <= 1'b1;
        cfg_index <= CFG_IDX_W'(r);
        cfg_data <= reg_value[r];
        @(posedge clk);
      end
    end
    cfg_write_enable <= 1'b0;
    if (write_mask[REG_WIDTH]) shadow_width = width_val;
    if (write_mask[REG_HEIGHT]) shadow_height = height_val;
    if (write_mask[REG_MODE]) shadow_rle = mode_val;
  endtask

  initial begin
    int unsigned phase_no;
    int unsigned w_eff;
    int unsigned h_eff;
    int unsigned n_steps;
    int unsigned pick;
    int unsigned run_len;
    int unsigned lit_len;
    int unsigned n_bytes;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Raw mode on a two-pixel, single-row image (a zero height counts as one
    // row). Both table entries used are written first, with opposite colours.
    // Two pixels end the row, two pad bytes finish the image, and the byte
    // after that is refused. The unused command must leave no trace.
    configure(13'd2, 13'd0, 1'b0, 3'b111);
    push_item(CMD_PAL_WRITE, 8'd0, 24'hFFFFFF, any_byte());
    push_item(CMD_PAL_WRITE, 8'd255, 24'h000000, any_byte());
    push_byte(8'd0);
    push_byte(8'd255);
    push_byte(8'd0);
    push_byte(8'd0);
    push_byte(8'd0);
    push_item(CMD_UNUSED, any_byte(), RGB_W'($urandom), any_byte());
    wait_idle();

    // RLE8 on an 8x2 image: an encoded run, end of line, a delta, an odd
    // absolute run with its pad byte, a run too long for the row, end of bitmap.
    configure(13'd8, 13'd2, 1'b1, 3'b111);
    push_item(CMD_NEW_IMAGE, any_byte(), RGB_W'($urandom), any_byte());
    push_byte(8'd3);
    push_byte(8'd0);
    push_byte(ESC_LEAD);
    push_byte(ESC_END_LINE);
    push_byte(ESC_LEAD);
    push_byte(ESC_DELTA);
    push_byte(8'd1);
    push_byte(8'd0);
    push_byte(ESC_LEAD);
    push_byte(8'd3);
    push_byte(8'd255);
    push_byte(8'd0);
    push_byte(8'd255);
    push_byte(8'd0);
    push_byte(8'd9);
    push_byte(8'd0);
    push_byte(ESC_LEAD);
    push_byte(ESC_END_IMAGE);
    wait_idle();

    // Fill the rest of the colour table so that any index may appear from
    // here on, noise bytes included.
    for (int i = 1; i < PALETTE_ENTRIES - 1; i++)
      push_item(CMD_PAL_WRITE, BYTE_W'(i), RGB_W'($urandom), any_byte());
    wait_idle();

    // Saturation: at the largest image, repeated maximal deltas drive both the
    // column and the row to the limit; the run there is refused, and end of
    // line cannot push the row further.
    configure('1, CFG_DIM_W'(MAX_DIMENSION), 1'b1, 3'b111);
    push_item(CMD_NEW_IMAGE, any_byte(), RGB_W'($urandom), any_byte());
    repeat (17) begin
      push_byte(ESC_LEAD);
      push_byte(ESC_DELTA);
      push_byte(8'd255);
      push_byte(8'd255);
    end
    push_byte(8'd1);
    push_byte(any_byte());
    push_byte(ESC_LEAD);
    push_byte(ESC_END_LINE);
    push_byte(ESC_LEAD);
    push_byte(ESC_END_IMAGE);
    push_byte(any_byte());
    wait_idle();

    // Random phases fill the stream up to its total size. Each one picks new
    // settings (mostly small images, now and then an extreme), usually starts
    // a new image, and then sends either raw pixel rows or a well-formed RLE8
    // stream with random content, with some noise, restarts and table
    // rewrites mixed in. Skipping the restart lets an image continue across a
    // change of mode.
    phase_no = 0;
    while (phase_no == 0 || items_pushed - ignored_items < TOTAL_ITEMS) begin
      configure((phase_no == 0) ? '0 : pick_dimension(12), pick_dimension(4),
                1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)));
      w_eff = clamp_dim(shadow_width);
      h_eff = clamp_dim(shadow_height);
      if ($urandom_range(0, 3) != 0)
        push_item(CMD_NEW_IMAGE, any_byte(), RGB_W'($urandom), any_byte());

      if (!shadow_rle) begin
        // Whole rows with their padding, plus up to three bytes past the end; past 48 bytes, 20 to 48 random bytes.
        n_bytes = (w_eff + (4 - w_eff % 4) % 4) * h_eff + $urandom_range(0, 3);
        if (n_bytes > 48) n_bytes = $urandom_range(20, 48);
        repeat (n_bytes) begin
          pick = $urandom_range(0, 99);
          if (pick < 2) push_item(CMD_NEW_IMAGE, any_byte(), RGB_W'($urandom), any_byte());
          else if (pick < 4) push_item(CMD_UNUSED, any_byte(), RGB_W'($urandom), any_byte());
          else push_byte(any_byte());
        end
      end else begin
        n_steps = $urandom_range(4, 16);
        repeat (n_steps) begin
          pick = $urandom_range(0, 99);
          if (pick < 40) begin
            run_len = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 255)
                                                  : $urandom_range(1, (w_eff < 8) ? w_eff : 8);
            push_byte(BYTE_W'(run_len));
            push_byte(any_byte());
          end else if (pick < 55) begin
            push_byte(ESC_LEAD);
            push_byte(ESC_END_LINE);
          end else if (pick < 65) begin
            push_byte(ESC_LEAD);
            push_byte(ESC_DELTA);
            push_byte(($urandom_range(0, 4) == 0) ? any_byte() : BYTE_W'($urandom_range(0, 3)));
            push_byte(($urandom_range(0, 4) == 0) ? any_byte() : BYTE_W'($urandom_range(0, 2)));
          end else if (pick < 85) begin
            lit_len = ($urandom_range(0, 9) == 0) ? $urandom_range(3, 60) : $urandom_range(3, 8);
            push_byte(ESC_LEAD);
            push_byte(BYTE_W'(lit_len));
            repeat (lit_len) push_byte(any_byte());
            if (lit_len % 2 != 0) push_byte(any_byte());
          end else if (pick < 90) begin
            push_byte(any_byte());
          end else if (pick < 94) begin
            push_item(CMD_PAL_WRITE, any_byte(), RGB_W'($urandom), any_byte());
          end else if (pick < 97) begin
            push_item(CMD_NEW_IMAGE, any_byte(), RGB_W'($urandom), any_byte());
          end else begin
            push_item(CMD_UNUSED, any_byte(), RGB_W'($urandom), any_byte());
          end
        end
        if ($urandom_range(0, 1) != 0) begin
          push_byte(ESC_LEAD);
          push_byte(ESC_END_IMAGE);
          repeat ($urandom_range(0, 2)) push_byte(any_byte());
        end
      end
      // The sender holds back here until every record of the phase is in.
      wait_idle();
      phase_no++;
    end

    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
